// ===== src/icu_pkg.sv =====
// Package: shared types and codes of the integer conversion unit.
package icu_pkg;
    localparam int unsigned OpW = 64;

    typedef enum logic [2:0] {
        REQ_SNARROW = 3'd0,
        REQ_UNARROW = 3'd1,
        REQ_S2D     = 3'd2,
        REQ_U2D     = 3'd3,
        REQ_BOOL    = 3'd4,
        REQ_COPY    = 3'd5
    } t_req;

    localparam logic [2:0] TGT_I1  = 3'd0;
    localparam logic [2:0] TGT_I16 = 3'd1;
    localparam logic [2:0] TGT_I32 = 3'd2;
    localparam logic [2:0] TGT_I64 = 3'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    typedef struct packed {
        logic [2:0]     req_type;
        logic [2:0]     target_kind;
        logic [OpW-1:0] operand;
    } t_in;

    typedef struct packed {
        logic [OpW-1:0] result_bits;
        logic [1:0]     status;
    } t_out;
endpackage

// ===== src/icu_if.sv =====
// Interfaces: valid/ready channels for requests and results.
interface icu_in_if import icu_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface icu_out_if import icu_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/icu_cvt.sv =====
// Combinational conversion datapath: narrowing checks, int to double, bool and copy.
module icu_cvt import icu_pkg::*; (
    input  t_in  i_req,
    output t_out o_res
);
    logic [63:0] v;
    logic        neg;
    logic [63:0] mag;
    logic [5:0]  p;
    logic [63:0] norm;
    logic [52:0] m;
    logic        g, st;
    logic [53:0] mr;
    logic [10:0] ex;
    logic [62:0] dbl;
    logic        ok;

    assign v = i_req.operand;

    // Magnitude and leading-one position
    always_comb begin
        neg = (i_req.req_type == REQ_S2D) && v[63];
        mag = neg ? (64'd0 - v) : v;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) p = 6'(i);
        end
    end

    // Normalize, round to nearest even
    always_comb begin
        norm = mag << (6'd63 - p);
        m    = norm[63:11];
        g    = norm[10];
        st   = |norm[9:0];
        mr   = {1'b0, m} + 54'(g & (st | m[0]));
        ex   = 11'(11'd1023 + {5'd0, p});
        if (mr[53]) begin
            ex = ex + 11'd1;
            dbl = {ex, 52'd0};
        end else begin
            dbl = {ex, mr[51:0]};
        end
        if (mag == 64'd0) dbl = 63'd0;
    end

    // Result select
    always_comb begin
        o_res.result_bits = v;
        o_res.status      = ST_OK;
        ok = 1'b1;
        case (i_req.req_type)
            REQ_SNARROW, REQ_UNARROW: begin
                case (i_req.target_kind)
                    TGT_I1:  ok = (v <= 64'd1);
                    TGT_I16: ok = (i_req.req_type == REQ_UNARROW || !v[63])
                                  ? (v <= 64'h7FFF) : (v >= 64'hFFFF_FFFF_FFFF_8000);
                    TGT_I32: ok = (i_req.req_type == REQ_UNARROW || !v[63])
                                  ? (v <= 64'h7FFF_FFFF) : (v >= 64'hFFFF_FFFF_8000_0000);
                    TGT_I64: ok = 1'b1;
                    default: begin
                        ok = 1'b0;
                        o_res.status = ST_UNSUP;
                    end
                endcase
                if (!ok) begin
                    o_res.result_bits = 64'd0;
                    if (o_res.status != ST_UNSUP) o_res.status = ST_RANGE;
                end
            end
            REQ_S2D, REQ_U2D: o_res.result_bits = {neg, dbl};
            REQ_BOOL:         o_res.result_bits = {63'd0, |v};
            default:          o_res.result_bits = v;
        endcase
    end
endmodule

// ===== src/integer_conversion_unit_top.sv =====
// Integer conversion unit: input register, conversion logic, result register.
//
// Channels: i_req (sink) takes req_type, target_kind and operand; o_res
// (source) gives result_bits and status, one result per request.
// A transferred request is registered in the input register; its result is
// computed from that register and loaded into the result register, from
// which it transfers to the receiver.
// Throughput: one request per cycle while the receiver takes results, set
// by the two-stage register pipeline.
// Each stage advances when its downstream slot is empty or being taken, so
// a stalled receiver holds the result and backs up the pipe; up to two
// requests are held in flight, and ready drops only when both are full.
// Reset clears both valid bits; payload registers are not reset.
// The unit keeps no state between requests.
module integer_conversion_unit_top import icu_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    icu_in_if.sink   i_req,
    icu_out_if.source o_res
);
    logic r_in_vld, n_in_vld;
    t_in  r_in;
    logic r_out_vld, n_out_vld;
    t_out r_out;
    t_out w_cvt;
    logic w_adv;
    logic w_take;

    icu_cvt u_cvt (.i_req(r_in), .o_res(w_cvt));

    // Stage handshakes
    assign w_adv  = r_in_vld && (!r_out_vld || o_res.ready);
    assign w_take = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_vld || w_adv;

    always_comb begin
        n_out_vld = w_adv ? 1'b1 : (r_out_vld && !o_res.ready);
        n_in_vld  = w_take ? 1'b1 : (r_in_vld && !w_adv);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_take) r_in <= i_req.data;
        if (w_adv) r_out <= w_cvt;
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;
endmodule

// ===== src/icu_chk.sv =====
// Checker: port-level assertions for the integer conversion unit, and bind.
module icu_chk import icu_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [63:0] i_bits
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_RANGE || i_status == ST_UNSUP))
        else $error("bad status");
    a_trap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> (i_bits == 64'd0))
        else $error("trap with nonzero result");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> ##1 i_out_valid)
        else $error("result missing");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_bits)))
        else $error("result dropped");
endmodule

bind integer_conversion_unit_top icu_chk u_icu_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_res.valid), .i_out_ready(o_res.ready),
    .i_status(o_res.data.status), .i_bits(o_res.data.result_bits)
);

// ===== tb/icu_tb_pkg.sv =====
// Testbench package: conversion predictor and result scoreboard.
`timescale 1ns / 100ps
package icu_tb_pkg;
    import icu_pkg::*;

    // Magnitude to binary64 bits (no sign), nearest-even rounding.
    function automatic logic [63:0] mag_to_f64(input logic [63:0] mag);
        int top;
        int sh;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [10:0] expo;
        if (mag == 64'd0) return 64'd0;
        top = 63;
        while (!mag[top]) top--;
        expo = 11'(1023 + top);
        if (top <= 52) begin
            mant = mag << (52 - top);
        end else begin
            sh = top - 52;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0])) mant++;
            // carry out of the mantissa bumps the exponent
            if (mant == (64'd1 << 53)) begin
                mant = mant >> 1;
                expo++;
            end
        end
        return {1'b0, expo, mant[51:0]};
    endfunction

    // Expected result of one conversion request.
    function automatic t_out convert(input t_in rq);
        t_out r;
        logic [63:0] v;
        logic fits;
        v = rq.operand;
        r.result_bits = '0;
        r.status = ST_OK;
        case (rq.req_type)
            REQ_SNARROW, REQ_UNARROW: begin
                fits = 1'b0;
                case (rq.target_kind)
                    TGT_I1:  fits = (v <= 64'd1);
                    TGT_I16: fits = (rq.req_type == REQ_UNARROW || !v[63]) ?
                        (v <= 64'h7FFF) : (v >= 64'hFFFF_FFFF_FFFF_8000);
                    TGT_I32: fits = (rq.req_type == REQ_UNARROW || !v[63]) ?
                        (v <= 64'h7FFF_FFFF) : (v >= 64'hFFFF_FFFF_8000_0000);
                    TGT_I64: fits = 1'b1;
                    default: r.status = ST_UNSUP;
                endcase
                if (r.status != ST_UNSUP) begin
                    if (fits) r.result_bits = v;
                    else r.status = ST_RANGE;
                end
            end
            REQ_S2D: r.result_bits = v[63] ? ({1'b1, 63'd0} | mag_to_f64(-v)) :
                mag_to_f64(v);
            REQ_U2D:  r.result_bits = mag_to_f64(v);
            REQ_BOOL: r.result_bits = (v != 0) ? 64'd1 : 64'd0;
            default:  r.result_bits = v;
        endcase
        return r;
    endfunction

    class conv_scoreboard;
        t_out pending[$];
        int errors = 0;

        function void note_request(t_in rq);
            pending.push_back(convert(rq));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %h/%0d",
                    got.result_bits, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.result_bits !== want.result_bits || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result exp %h/%0d got %h/%0d", want.result_bits,
                        want.status, got.result_bits, got.status);
            end
        endfunction
    endclass
endpackage

// ===== tb/integer_conversion_unit_top_test.sv =====
// Testbench top: drives requests, stalls results, checks conversions.
`timescale 1ns / 100ps
module integer_conversion_unit_top_test;
    import icu_pkg::*;
    import icu_tb_pkg::*;

    localparam int NumRandom = 1650;
    localparam int CalmTail = 200;
    localparam longint CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_done = 1'b0;
    logic hold_off = 1'b0;
    logic calm = 1'b0;
    longint cycles = 0;
    conv_scoreboard sb = new();

    icu_in_if  req_ch ();
    icu_out_if res_ch ();

    integer_conversion_unit_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    // Random operand biased toward range edges.
    function automatic logic [63:0] pick_operand();
        logic [63:0] edges[12] = '{64'd0, 64'd1, 64'd2, 64'h7FFF, 64'h8000,
            64'hFFFF_FFFF_FFFF_8000, 64'hFFFF_FFFF_FFFF_7FFF, 64'h7FFF_FFFF,
            64'h8000_0000, 64'hFFFF_FFFF_8000_0000, 64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFF};
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return edges[$urandom_range(0, 11)];
            1: return edges[$urandom_range(0, 11)] + 64'($signed(5'($urandom)));
            2: return r >> $urandom_range(0, 63);
            // near halfway points of the double rounding
            3: return (r | 64'h8000_0000_0000_0000) >> $urandom_range(0, 11)
                   & ~64'h3FF | (64'($urandom_range(0, 3)) << 9) | 64'($urandom_range(0, 1));
            default: return r;
        endcase
    endfunction

    // Offer one request and wait for its transfer; entered at a falling edge.
    task automatic send(input logic [2:0] rt, input logic [2:0] tk, input logic [63:0] op);
        t_in rq;
        rq.req_type = rt;
        rq.target_kind = tk;
        rq.operand = op;
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        req_ch.data <= rq;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(rq);
        @(negedge i_clk);
    endtask

    // Result side: random stall bursts, optional long hold-off.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) res_ch.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge i_clk);
            end else res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold the receiver off for a long stretch while requests keep coming.
    initial begin
        int n;
        wait (in_done == 1'b0 && i_rst_n);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
        hold_off = 1'b1;
        for (n = 0; n < 60; n++) @(posedge i_clk);
        @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        logic [63:0] ops[8] = '{64'd0, 64'd1, 64'h7FFF, 64'hFFFF_FFFF_FFFF_8000,
            64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0020_0000_0000_0001,
            64'h0060_0000_0000_0002};
        int k;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: every op, every target incl. unsupported, edge operands
        for (k = 0; k < 8; k++) send(REQ_SNARROW, 3'(k), ops[k]);
        for (k = 0; k < 8; k++) send(REQ_UNARROW, 3'(k), ops[7 - k]);
        send(REQ_S2D, TGT_I1, ops[4]);
        send(REQ_S2D, 3'd7, ops[5]);
        send(REQ_U2D, TGT_I1, ops[5]);
        send(REQ_U2D, TGT_I1, ops[0]);
        send(REQ_U2D, TGT_I1, ops[6]);
        send(REQ_BOOL, TGT_I1, ops[4]);
        send(REQ_BOOL, TGT_I1, ops[0]);
        send(REQ_COPY, TGT_I1, ops[5]);
        send(3'd6, TGT_I1, ops[3]);
        send(3'd7, TGT_I1, ops[2]);
        for (k = 0; k < NumRandom; k++) begin
            if (k == NumRandom - CalmTail) calm = 1'b1;
            send(3'($urandom_range(0, 9) < 6 ? $urandom_range(0, 1) : $urandom_range(0, 7)),
                3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(0, 7)),
                pick_operand());
        end
        req_ch.valid <= 1'b0;
        in_done = 1'b1;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/icu_pkg.sv
src/icu_if.sv
src/icu_cvt.sv
src/integer_conversion_unit_top.sv
src/icu_chk.sv
tb/icu_tb_pkg.sv
tb/integer_conversion_unit_top_test.sv
